// ===== rtl/spt_pkg.sv =====
package spt_pkg;

  // Longest path in bytes; a byte arriving after this many is rejected.
  localparam int MAX_LEN = 256;
  // Byte counter and token start hold 0 .. MAX_LEN.
  localparam int POS_W = $clog2(MAX_LEN + 1);

  // Verdict codes.
  localparam logic [1:0] VERD_NONE   = 2'd0;
  localparam logic [1:0] VERD_ACCEPT = 2'd1;
  localparam logic [1:0] VERD_REJECT = 2'd2;

  // Token kinds.
  localparam logic [1:0] TOK_NONE   = 2'd0;
  localparam logic [1:0] TOK_ROUTE  = 2'd1;
  localparam logic [1:0] TOK_LOCAL  = 2'd2;
  localparam logic [1:0] TOK_MDOM   = 2'd3;

  // Byte classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_LT,
    CLS_GT,
    CLS_AT,
    CLS_COMMA,
    CLS_COLON,
    CLS_OTHER
  } spt_cls_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } spt_in_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] token_start;
    logic [7:0] token_len;
    logic [1:0] verdict;
    logic [7:0] trailing_pos;
  } spt_out_t;

  // Classified word as it travels through the queue.
  typedef struct packed {
    logic     is_end;
    spt_cls_t cls;
  } spt_item_t;

  function automatic spt_cls_t spt_classify(input logic [7:0] c);
    spt_cls_t cls;
    unique case (c)
      8'd13, 8'd10, 8'd9, 8'd32: cls = CLS_SPACE;
      8'd60:                     cls = CLS_LT;
      8'd62:                     cls = CLS_GT;
      8'd64:                     cls = CLS_AT;
      8'd44:                     cls = CLS_COMMA;
      8'd58:                     cls = CLS_COLON;
      default:                   cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// ===== rtl/spt_front.sv =====
module spt_front
  import spt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  spt_in_t   in_data,
  output logic      push_valid,
  input  logic      push_ready,
  output spt_item_t push_item
);

  logic      valid_r, valid_nxt;
  spt_item_t item_r, item_nxt;
  logic      load;

  // The holding register refills whenever it is empty or hands its word on.
  assign load     = !valid_r || push_ready;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt       = in_valid;
      item_nxt.is_end = in_data.is_end;
      item_nxt.cls    = spt_classify(in_data.ch);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule

// ===== rtl/spt_queue.sv =====
module spt_queue
  import spt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  spt_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output spt_item_t pop_item
);

  spt_item_t  mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/spt_back.sv =====
module spt_back
  import spt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  spt_item_t pop_item,
  output logic      out_valid,
  input  logic      out_stall,
  output spt_out_t  out_data
);

  typedef enum logic [2:0] {
    PH_OPEN,
    PH_SEP,
    PH_ROUTE,
    PH_LOCAL,
    PH_MDOM,
    PH_FINAL
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             decided_r, decided_nxt;
  logic [1:0]       final_r, final_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] tok_r, tok_nxt;
  logic             trail_r, trail_nxt;
  logic             out_valid_r, out_valid_nxt;
  spt_out_t         out_r, out_nxt;

  logic             pop;
  logic             empty_tok;
  logic [POS_W-1:0] tok_len;
  logic [POS_W-1:0] pos_inc;
  spt_out_t         res;

  assign pop_ready = !out_valid_r || !out_stall;
  assign pop       = pop_valid && pop_ready;
  assign empty_tok = (tok_r >= pos_r);
  assign tok_len   = pos_r - tok_r;
  assign pos_inc   = pos_r + POS_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    decided_nxt = decided_r;
    final_nxt   = final_r;
    pos_nxt     = pos_r;
    tok_nxt     = tok_r;
    trail_nxt   = cfg_we ? cfg_wdata : trail_r;
    res         = '0;

    if (pop) begin
      if (pop_item.is_end) begin
        res.verdict = decided_r ? final_r
                    : ((phase_r == PH_FINAL) ? VERD_ACCEPT : VERD_REJECT);
        phase_nxt   = PH_OPEN;
        decided_nxt = 1'b0;
        final_nxt   = VERD_NONE;
        pos_nxt     = '0;
        tok_nxt     = '0;
      end else if (!decided_r) begin
        if (pos_r >= POS_W'(MAX_LEN)) begin
          res.verdict = VERD_REJECT;
        end else begin
          unique case (phase_r)
            PH_OPEN: begin
              if (pop_item.cls == CLS_LT) begin
                phase_nxt = PH_SEP;
              end else begin
                res.verdict = VERD_REJECT;
              end
            end
            PH_SEP: begin
              case (pop_item.cls)
                CLS_SPACE: ;
                CLS_AT: begin
                  phase_nxt = PH_ROUTE;
                  tok_nxt   = pos_inc;
                end
                CLS_GT: phase_nxt = PH_FINAL;
                default: begin
                  phase_nxt = PH_LOCAL;
                  tok_nxt   = pos_r;
                end
              endcase
            end
            PH_ROUTE: begin
              if (pop_item.cls inside {CLS_COMMA, CLS_COLON}) begin
                if (empty_tok) begin
                  res.verdict = VERD_REJECT;
                end else begin
                  res.token_kind  = TOK_ROUTE;
                  res.token_start = tok_r[7:0];
                  res.token_len   = tok_len[7:0];
                  if (pop_item.cls == CLS_COMMA) begin
                    phase_nxt = PH_SEP;
                  end else begin
                    phase_nxt = PH_LOCAL;
                    tok_nxt   = pos_inc;
                  end
                end
              end
            end
            PH_LOCAL: begin
              if (pop_item.cls == CLS_AT) begin
                if (empty_tok) begin
                  res.verdict = VERD_REJECT;
                end else begin
                  res.token_kind  = TOK_LOCAL;
                  res.token_start = tok_r[7:0];
                  res.token_len   = tok_len[7:0];
                  phase_nxt       = PH_MDOM;
                  tok_nxt         = pos_inc;
                end
              end
            end
            PH_MDOM: begin
              if (pop_item.cls == CLS_GT) begin
                if (empty_tok) begin
                  res.verdict = VERD_REJECT;
                end else begin
                  res.token_kind  = TOK_MDOM;
                  res.token_start = tok_r[7:0];
                  res.token_len   = tok_len[7:0];
                  phase_nxt       = PH_FINAL;
                end
              end
            end
            default: begin
              if (trail_r) begin
                res.verdict      = VERD_ACCEPT;
                res.trailing_pos = pos_r[7:0];
              end else if (pop_item.cls != CLS_SPACE) begin
                res.verdict = VERD_REJECT;
              end
            end
          endcase
        end
        if (res.verdict != VERD_NONE) begin
          decided_nxt = 1'b1;
          final_nxt   = res.verdict;
        end
        if (pos_r < POS_W'(MAX_LEN)) begin
          pos_nxt = pos_inc;
        end
      end
    end

    // Output register: refills on every pop, clears once its word is taken.
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (pop_ready) begin
      out_valid_nxt = pop;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      decided_r   <= 1'b0;
      final_r     <= VERD_NONE;
      pos_r       <= '0;
      tok_r       <= '0;
      trail_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      decided_r   <= decided_nxt;
      final_r     <= final_nxt;
      pos_r       <= pos_nxt;
      tok_r       <= tok_nxt;
      trail_r     <= trail_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/smtp_path_tokenizer_top.sv =====
// Channel   Direction  Handshake             Word
// in_       input      in_valid / in_stall   spt_in_t  {ch, is_end}
// out_      output     out_valid / out_stall spt_out_t {token_kind, token_start,
//                                                       token_len, verdict, trailing_pos}
// cfg_      input      cfg_we (no wait)      cfg_wdata = trailing_mode
//
// One word is accepted per cycle while in_stall is low, and each word gives
// exactly one result word. When nothing stalls, the word passes the front
// holding register, the queue and the output register before out_valid rises.
// The parse update in the back end is combinational and sets the rate of one.
// Reset is synchronous and active low; it clears the parse state, the queue
// and the trailing mode register.
// A stall on the output fills the two-entry queue and then the front holding
// register before in_stall rises, so each side can stall independently.

module smtp_path_tokenizer_top
  import spt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  spt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output spt_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  // Front to queue.
  logic      push_valid;
  logic      push_ready;
  spt_item_t push_item;

  // Queue to back end.
  logic      pop_valid;
  logic      pop_ready;
  spt_item_t pop_item;

  // The front end classifies each byte into a small code, so the back end
  // only ever sees separators, whitespace and "other".
  spt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // A two-entry queue decouples the classifier from the parser.
  spt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The back end runs the six-phase parse, tracks the byte offset and token
  // start, and registers the result word.
  spt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
